// ===== rtl/core/ipv4_receive_header_check_macros.svh =====
// Assertion macros for the IPv4 receive header check.
`ifndef IPV4_RECEIVE_HEADER_CHECK_MACROS_SVH
`define IPV4_RECEIVE_HEADER_CHECK_MACROS_SVH

`ifndef SYNTHESIS

`define IPV4RX_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define IPV4RX_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define IPV4RX_ASSERT(label, prop, msg)

`define IPV4RX_NEVER(label, cond, msg)

`endif

`endif

// ===== rtl/core/ipv4rx_pkg.sv =====
package ipv4rx_pkg;

	localparam logic [15:0] MIN_HEADER_BYTES = 16'd20;
	localparam logic [31:0] BROADCAST_ADDR   = 32'hFFFF_FFFF;
	localparam logic [15:0] COUNT_MAX        = 16'hFFFF;
	localparam logic [3:0]  IP_VERSION       = 4'd4;

	localparam logic [15:0] IDX_VER_IHL = 16'd0;
	localparam logic [15:0] IDX_TLEN_HI = 16'd2;
	localparam logic [15:0] IDX_TLEN_LO = 16'd3;
	localparam logic [15:0] IDX_PROTO   = 16'd9;
	localparam logic [15:0] IDX_CSUM_HI = 16'd10;
	localparam logic [15:0] IDX_CSUM_LO = 16'd11;
	localparam logic [15:0] IDX_DST_0   = 16'd16;
	localparam logic [15:0] IDX_DST_1   = 16'd17;
	localparam logic [15:0] IDX_DST_2   = 16'd18;
	localparam logic [15:0] IDX_DST_3   = 16'd19;

	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	localparam int OUT_DATA_W = 40;

	typedef enum logic [3:0] {
		V_TCP       = 4'd0,
		V_UDP       = 4'd1,
		V_ICMP      = 4'd2,
		V_UNKNOWN   = 4'd3,
		V_SHORT     = 4'd4,
		V_BAD_HDR   = 4'd5,
		V_LENGTH    = 4'd6,
		V_NOT_OURS  = 4'd7,
		V_CHECKSUM  = 4'd8
	} verdict_t;

	typedef struct packed {
		logic [15:0] byte_count;
		logic [7:0]  ver_hl;
		logic [15:0] tot_len;
		logic [31:0] dest_address;
		logic [7:0]  protocol;
		logic [15:0] rx_checksum;
		logic [16:0] checksum_sum;
	} pkt_info_t;

	typedef struct packed {
		logic [5:0]  header_length;
		logic [15:0] payload_length;
		logic [7:0]  protocol;
		verdict_t    verdict;
	} result_t;

	function automatic logic [16:0] add_word(input logic [16:0] sum, input logic [15:0] word);
		logic [17:0] s;
		logic [16:0] r;
		s = {1'b0, sum} + {2'b00, word};
		if (s > 18'h0FFFF) begin
			r = {1'b0, s[15:0]} + 17'd1;
		end else begin
			r = s[16:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/ipv4rx_hdr_track.sv =====
module ipv4rx_hdr_track
	import ipv4rx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output pkt_info_t   info
);

	logic [15:0] count_q;
	logic [7:0]  ver_ihl_q;
	logic [15:0] tlen_q;
	logic [31:0] dst_q;
	logic [7:0]  proto_q;
	logic [15:0] rcsum_q;
	logic [16:0] sum_q;
	logic [7:0]  hold_q;

	logic [7:0]  ver_ihl_n;
	logic [15:0] tlen_n;
	logic [31:0] dst_n;
	logic [7:0]  proto_n;
	logic [15:0] rcsum_n;
	logic [16:0] sum_n;
	logic [7:0]  hold_n;
	logic [15:0] count_n;
	logic [15:0] hdr_bytes;
	logic [7:0]  csum_byte;

	always_comb begin
		ver_ihl_n = (count_q == IDX_VER_IHL) ? data_byte : ver_ihl_q;
		hdr_bytes = {10'd0, ver_ihl_n[3:0], 2'b00};
		tlen_n    = tlen_q;
		dst_n     = dst_q;
		proto_n   = proto_q;
		rcsum_n   = rcsum_q;
		case (count_q) inside
			IDX_TLEN_HI: tlen_n = {data_byte, tlen_q[7:0]};
			IDX_TLEN_LO: tlen_n = {tlen_q[15:8], data_byte};
			IDX_PROTO:   proto_n = data_byte;
			IDX_CSUM_HI: rcsum_n = {data_byte, rcsum_q[7:0]};
			IDX_CSUM_LO: rcsum_n = {rcsum_q[15:8], data_byte};
			IDX_DST_0, IDX_DST_1, IDX_DST_2, IDX_DST_3: dst_n = {dst_q[23:0], data_byte};
			default: ;
		endcase

		// checksum field counts as zero
		csum_byte = (count_q == IDX_CSUM_HI || count_q == IDX_CSUM_LO) ? 8'd0 : data_byte;
		hold_n    = hold_q;
		sum_n     = sum_q;
		if (count_q < hdr_bytes) begin
			if (!count_q[0]) begin
				hold_n = csum_byte;
			end else begin
				sum_n = add_word(sum_q, {hold_q, csum_byte});
			end
		end

		count_n = (count_q != COUNT_MAX) ? count_q + 16'd1 : count_q;
	end

	assign info = '{
		byte_count:   count_n,
		ver_hl:       ver_ihl_n,
		tot_len:      tlen_n,
		dest_address: dst_n,
		protocol:     proto_n,
		rx_checksum:  rcsum_n,
		checksum_sum: sum_n
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			ver_ihl_q <= '0;
			tlen_q    <= '0;
			dst_q     <= '0;
			proto_q   <= '0;
			rcsum_q   <= '0;
			sum_q     <= '0;
			hold_q    <= '0;
		end else if (en) begin
			if (last_byte) begin
				count_q   <= '0;
				ver_ihl_q <= '0;
				tlen_q    <= '0;
				dst_q     <= '0;
				proto_q   <= '0;
				rcsum_q   <= '0;
				sum_q     <= '0;
				hold_q    <= '0;
			end else begin
				count_q   <= count_n;
				ver_ihl_q <= ver_ihl_n;
				tlen_q    <= tlen_n;
				dst_q     <= dst_n;
				proto_q   <= proto_n;
				rcsum_q   <= rcsum_n;
				sum_q     <= sum_n;
				hold_q    <= hold_n;
			end
		end
	end

endmodule

// ===== rtl/core/ipv4rx_verdict.sv =====
module ipv4rx_verdict
	import ipv4rx_pkg::*;
(
	input  pkt_info_t   info,
	input  logic [31:0] local_address,
	output result_t     result
);

	logic [15:0] hdr_bytes;
	logic [15:0] calc_csum;
	verdict_t    verdict;
	logic [15:0] payload;

	always_comb begin
		hdr_bytes = {10'd0, info.ver_hl[3:0], 2'b00};
		calc_csum = ~info.checksum_sum[15:0];
		payload   = '0;
		if (info.byte_count < MIN_HEADER_BYTES) begin
			verdict = V_SHORT;
		end else if (info.ver_hl[7:4] != IP_VERSION || hdr_bytes < MIN_HEADER_BYTES
				|| info.byte_count < hdr_bytes) begin
			verdict = V_BAD_HDR;
		end else if (info.tot_len > info.byte_count) begin
			verdict = V_LENGTH;
		end else if (info.dest_address != local_address
				&& info.dest_address != BROADCAST_ADDR) begin
			verdict = V_NOT_OURS;
		end else if (info.rx_checksum != calc_csum) begin
			verdict = V_CHECKSUM;
		end else begin
			unique case (info.protocol)
				PROTO_TCP:  verdict = V_TCP;
				PROTO_UDP:  verdict = V_UDP;
				PROTO_ICMP: verdict = V_ICMP;
				default:    verdict = V_UNKNOWN;
			endcase
			payload = (info.tot_len >= hdr_bytes) ? info.tot_len - hdr_bytes : 16'd0;
		end
	end

	assign result = '{
		header_length:  hdr_bytes[5:0],
		payload_length: payload,
		protocol:       info.protocol,
		verdict:        verdict
	};

endmodule

// ===== rtl/core/ipv4_receive_header_check.sv =====
// channel   | dir | handshake          | contents
// ----------+-----+--------------------+-------------------------------------------
// s_*       | in  | s_tvalid/s_tready  | tdata[7:0] data_byte, tlast last_byte
// m_*       | out | m_tvalid/m_tready  | tdata verdict, protocol, payload_length, hdr len
// cfg_*     | in  | cfg_we             | cfg_wdata local_address
//
// One byte per cycle unless a finished result waits on m_tready. A byte is registered
// at the input; header capture, checksum add and verdict then feed the result register.
// m_tvalid rises when the last byte leaves the input register for the result register.
// A waiting result stalls only a last byte; other bytes keep flowing.
// arst_n clears packet state, local_address and both handshake registers.
`include "ipv4_receive_header_check_macros.svh"

module ipv4_receive_header_check
	import ipv4rx_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [31:0]           cfg_wdata,  // local_address
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,    // [7:0] data_byte
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata     // [3:0] verdict, [11:4] protocol,
	                                          // [27:12] payload_length, [33:28] header_length
);

	logic [31:0] local_addr_q;
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        out_valid_q;
	result_t     out_q;
	logic        advance;
	pkt_info_t   info;
	result_t     result;

	assign advance  = !last_s1 || !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_addr_q <= '0;
		end else if (cfg_we) begin
			local_addr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
			last_s1  <= s_tvalid && s_tlast;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
		end
	end

	ipv4rx_hdr_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (valid_s1 && advance),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.info      (info)
	);

	ipv4rx_verdict u_verdict (
		.info          (info),
		.local_address (local_addr_q),
		.result        (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && last_s1 && advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && last_s1 && advance) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, out_q};

	`IPV4RX_ASSERT(a_result_follows_last, valid_s1 && last_s1 && advance |=> m_tvalid, "last word produced no result")
	`IPV4RX_NEVER(a_verdict_range, m_tvalid && m_tdata[3:0] > V_CHECKSUM, "verdict out of range")
	`IPV4RX_ASSERT(a_reject_no_payload, m_tvalid && m_tdata[3:0] >= V_SHORT |-> m_tdata[27:12] == 16'd0, "payload length on rejected packet")
	`IPV4RX_NEVER(a_hdr_len_align, m_tvalid && m_tdata[29:28] != 2'b00, "header length not a multiple of four")

endmodule

// ===== sim/tb_ipv4_receive_header_check.sv =====
`timescale 1ns / 1ps

module tb_ipv4_receive_header_check;
	import ipv4rx_pkg::*;

	localparam logic [31:0] LOCAL_A = 32'hC0A8_0A01;
	localparam int unsigned RANDOM_WORDS = 700;
	localparam int unsigned RANDOM_PACKETS = 48;

	// One packet to send; exp is used only where typed is set.
	typedef struct packed {
		logic [16:0] len;
		logic [3:0]  version;
		logic [3:0]  ihl;
		logic [15:0] tot_len;
		logic [7:0]  proto;
		logic [31:0] dest;
		logic        bad_csum;
		logic [7:0]  fill;
		logic        typed;
		result_t     exp;
	} pkt_plan_t;

	// exp order: header_length, payload_length, protocol, verdict
	localparam pkt_plan_t DIRECTED_PLAN [22] = '{
		'{17'd1, 4'd4, 4'd5, 16'd20, 8'd6, LOCAL_A, 1'b0, 8'h00, 1'b1,
			'{6'd20, 16'd0, 8'd0, V_SHORT}},
		'{17'd19, 4'd4, 4'd5, 16'd19, 8'd6, LOCAL_A, 1'b0, 8'h00, 1'b1,
			'{6'd20, 16'd0, 8'd6, V_SHORT}},
		'{17'd20, 4'd4, 4'd5, 16'd20, 8'd6, LOCAL_A, 1'b0, 8'h00, 1'b1,
			'{6'd20, 16'd0, 8'd6, V_TCP}},
		'{17'd28, 4'd4, 4'd5, 16'd28, 8'd17, BROADCAST_ADDR, 1'b0, 8'h00, 1'b1,
			'{6'd20, 16'd8, 8'd17, V_UDP}},
		'{17'd24, 4'd4, 4'd5, 16'd24, 8'd1, LOCAL_A, 1'b0, 8'hFF, 1'b1,
			'{6'd20, 16'd4, 8'd1, V_ICMP}},
		'{17'd20, 4'd4, 4'd5, 16'd20, 8'hFF, LOCAL_A, 1'b0, 8'h00, 1'b1,
			'{6'd20, 16'd0, 8'hFF, V_UNKNOWN}},
		'{17'd20, 4'd4, 4'd5, 16'd20, 8'h00, LOCAL_A, 1'b0, 8'hFF, 1'b1,
			'{6'd20, 16'd0, 8'h00, V_UNKNOWN}},
		'{17'd20, 4'd6, 4'd5, 16'd20, 8'd6, LOCAL_A, 1'b0, 8'h00, 1'b1,
			'{6'd20, 16'd0, 8'd6, V_BAD_HDR}},
		'{17'd60, 4'hF, 4'hF, 16'd60, 8'd6, LOCAL_A, 1'b0, 8'hFF, 1'b1,
			'{6'd60, 16'd0, 8'd6, V_BAD_HDR}},
		'{17'd20, 4'd4, 4'd0, 16'd20, 8'd6, LOCAL_A, 1'b0, 8'h00, 1'b1,
			'{6'd0, 16'd0, 8'd6, V_BAD_HDR}},
		'{17'd20, 4'd4, 4'd4, 16'd20, 8'd6, LOCAL_A, 1'b0, 8'h00, 1'b1,
			'{6'd16, 16'd0, 8'd6, V_BAD_HDR}},
		'{17'd40, 4'd4, 4'hF, 16'd40, 8'd6, LOCAL_A, 1'b0, 8'h00, 1'b1,
			'{6'd60, 16'd0, 8'd6, V_BAD_HDR}},
		'{17'd60, 4'd4, 4'hF, 16'd60, 8'd6, LOCAL_A, 1'b0, 8'hFF, 1'b0, result_t'('0)},
		'{17'd20, 4'd4, 4'd5, 16'd21, 8'd6, LOCAL_A, 1'b0, 8'h00, 1'b1,
			'{6'd20, 16'd0, 8'd6, V_LENGTH}},
		'{17'd30, 4'd4, 4'd5, 16'hFFFF, 8'd6, LOCAL_A, 1'b0, 8'hFF, 1'b1,
			'{6'd20, 16'd0, 8'd6, V_LENGTH}},
		'{17'd20, 4'd4, 4'd5, 16'd20, 8'd6, 32'h0A00_0001, 1'b0, 8'h00, 1'b1,
			'{6'd20, 16'd0, 8'd6, V_NOT_OURS}},
		'{17'd20, 4'd4, 4'd5, 16'd20, 8'd6, 32'h0, 1'b0, 8'h00, 1'b1,
			'{6'd20, 16'd0, 8'd6, V_NOT_OURS}},
		'{17'd20, 4'd4, 4'd5, 16'd20, 8'd6, LOCAL_A, 1'b1, 8'h00, 1'b1,
			'{6'd20, 16'd0, 8'd6, V_CHECKSUM}},
		'{17'd20, 4'd4, 4'd5, 16'd8, 8'd17, LOCAL_A, 1'b0, 8'h00, 1'b1,
			'{6'd20, 16'd0, 8'd17, V_UDP}},
		'{17'd20, 4'd4, 4'd5, 16'd0, 8'd6, LOCAL_A, 1'b0, 8'hFF, 1'b1,
			'{6'd20, 16'd0, 8'd6, V_TCP}},
		'{17'd300, 4'd4, 4'd6, 16'd100, 8'd6, LOCAL_A, 1'b0, 8'hA5, 1'b0, result_t'('0)},
		// byte count saturates well before the end
		'{17'd66000, 4'd4, 4'd5, 16'hFFFF, 8'd17, LOCAL_A, 1'b0, 8'h5A, 1'b1,
			'{6'd20, 16'd65515, 8'd17, V_UDP}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;    // [7:0] data_byte
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata; // [3:0] verdict, [11:4] protocol,
	                                // [27:12] payload_length, [33:28] header_length

	// predictor state
	logic [31:0] local_addr_shadow = '0;
	logic [15:0] rx_count = '0;
	logic [7:0]  rx_ver_ihl = '0;
	logic [15:0] rx_total_len = '0;
	logic [31:0] rx_dest = '0;
	logic [7:0]  rx_proto = '0;
	logic [15:0] rx_csum_field = '0;
	logic [16:0] rx_sum = '0;
	logic [7:0]  rx_hi_byte = '0;

	result_t     pending_verdicts [$];
	logic [7:0]  pkt_bytes [$];
	int unsigned mismatch_count = 0;
	int unsigned random_words = 0;
	bit          steady_send = 1'b0;
	bit          steady_recv = 1'b0;
	int unsigned stall_left = 0;

	ipv4_receive_header_check u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #2 clk = ~clk;

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 12) begin
			return 0;
		end else if (r < 18) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic predict_verdict(input logic [7:0] b, input logic last, output bit hit,
		output result_t r);
		logic [15:0] idx;
		logic [15:0] hdr;
		logic [15:0] calc;
		logic [7:0]  v;
		logic [17:0] s;
		idx = rx_count;
		if (idx == IDX_VER_IHL) rx_ver_ihl = b;
		hdr = {10'd0, rx_ver_ihl[3:0], 2'b00};
		case (idx)
			IDX_TLEN_HI: rx_total_len[15:8] = b;
			IDX_TLEN_LO: rx_total_len[7:0] = b;
			IDX_PROTO: rx_proto = b;
			IDX_CSUM_HI: rx_csum_field[15:8] = b;
			IDX_CSUM_LO: rx_csum_field[7:0] = b;
			IDX_DST_0, IDX_DST_1, IDX_DST_2, IDX_DST_3: rx_dest = {rx_dest[23:0], b};
			default: ;
		endcase
		if (idx < hdr) begin
			v = (idx == IDX_CSUM_HI || idx == IDX_CSUM_LO) ? 8'd0 : b;
			if (!idx[0]) begin
				rx_hi_byte = v;
			end else begin
				s = rx_sum + {rx_hi_byte, v};
				rx_sum = (s[17:16] != 2'b00) ? {1'b0, s[15:0]} + 17'd1 : s[16:0];
			end
		end
		if (rx_count != COUNT_MAX) rx_count++;
		hit = last;
		r = '0;
		if (last) begin
			calc = ~rx_sum[15:0];
			r.protocol = rx_proto;
			r.header_length = hdr[5:0];
			if (rx_count < MIN_HEADER_BYTES) begin
				r.verdict = V_SHORT;
			end else if (rx_ver_ihl[7:4] != IP_VERSION || hdr < MIN_HEADER_BYTES
				|| rx_count < hdr) begin
				r.verdict = V_BAD_HDR;
			end else if (rx_total_len > rx_count) begin
				r.verdict = V_LENGTH;
			end else if (rx_dest != local_addr_shadow && rx_dest != BROADCAST_ADDR) begin
				r.verdict = V_NOT_OURS;
			end else if (rx_csum_field != calc) begin
				r.verdict = V_CHECKSUM;
			end else begin
				case (rx_proto)
					PROTO_TCP: r.verdict = V_TCP;
					PROTO_UDP: r.verdict = V_UDP;
					PROTO_ICMP: r.verdict = V_ICMP;
					default: r.verdict = V_UNKNOWN;
				endcase
				r.payload_length = (rx_total_len >= hdr) ? rx_total_len - hdr : 16'd0;
			end
			rx_count = '0;
			rx_ver_ihl = '0;
			rx_total_len = '0;
			rx_dest = '0;
			rx_proto = '0;
			rx_csum_field = '0;
			rx_sum = '0;
			rx_hi_byte = '0;
		end
	endtask

	// Lays out header and body; the checksum covers ihl*4 bytes.
	task automatic build_packet(input pkt_plan_t p, input bit random_body);
		logic [7:0]  hdr_img [60];
		logic [31:0] sum;
		logic [15:0] csum;
		int unsigned hlen;
		hlen = p.ihl * 4;
		for (int i = 0; i < 60; i++) begin
			hdr_img[i] = random_body ? 8'($urandom) : p.fill;
		end
		hdr_img[0] = {p.version, p.ihl};
		hdr_img[2] = p.tot_len[15:8];
		hdr_img[3] = p.tot_len[7:0];
		hdr_img[9] = p.proto;
		hdr_img[10] = 8'd0;
		hdr_img[11] = 8'd0;
		for (int i = 0; i < 4; i++) begin
			hdr_img[16 + i] = p.dest[31 - 8 * i -: 8];
		end
		sum = '0;
		for (int i = 0; i < hlen; i += 2) begin
			sum += {hdr_img[i], hdr_img[i + 1]};
		end
		sum = sum[15:0] + sum[31:16];
		sum = sum[15:0] + sum[31:16];
		csum = ~sum[15:0];
		if (p.bad_csum) csum ^= 16'($urandom_range(1, 65535));
		hdr_img[10] = csum[15:8];
		hdr_img[11] = csum[7:0];
		pkt_bytes.delete();
		for (int i = 0; i < p.len; i++) begin
			pkt_bytes.push_back(i < 60 ? hdr_img[i] : (random_body ? 8'($urandom) : p.fill));
		end
	endtask

	task automatic send_word(input logic [7:0] b, input logic last, output bit hit,
		output result_t r);
		int unsigned g;
		g = steady_send ? 0 : pick_gap();
		if (g != 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		predict_verdict(b, last, hit, r);
	endtask

	task automatic send_packet(input bit typed, input result_t typed_r);
		bit      hit;
		result_t r;
		foreach (pkt_bytes[i]) begin
			send_word(pkt_bytes[i], i == pkt_bytes.size() - 1, hit, r);
			if (hit) pending_verdicts.push_back(typed ? typed_r : r);
		end
	endtask

	task automatic wait_all_verdicts();
		s_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_local(input logic [31:0] a);
		cfg_we <= 1'b1;
		cfg_wdata <= a;
		@(posedge clk);
		cfg_we <= 1'b0;
		local_addr_shadow = a;
	endtask

	// Mostly well-formed packets with random content, some damaged, some noise.
	task automatic send_random_packet();
		pkt_plan_t   p;
		int unsigned pay;
		if ($urandom_range(0, 4) == 0) begin
			pkt_bytes.delete();
			repeat ($urandom_range(1, 30)) pkt_bytes.push_back(8'($urandom));
		end else begin
			p = '0;
			p.version = IP_VERSION;
			p.ihl = ($urandom_range(0, 9) < 7) ? 4'd5 : 4'($urandom_range(5, 15));
			pay = $urandom_range(0, 24);
			p.len = 17'(p.ihl * 4 + pay);
			p.tot_len = ($urandom_range(0, 3) != 0) ? 16'(p.len)
				: 16'($urandom_range(0, p.len));
			case ($urandom_range(0, 4))
				0: p.proto = PROTO_TCP;
				1: p.proto = PROTO_UDP;
				2: p.proto = PROTO_ICMP;
				default: p.proto = 8'($urandom);
			endcase
			case ($urandom_range(0, 3))
				0, 1: p.dest = local_addr_shadow;
				2: p.dest = BROADCAST_ADDR;
				default: p.dest = $urandom;
			endcase
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 5))
					0: p.bad_csum = 1'b1;
					1: p.version = 4'($urandom_range(0, 15));
					2: p.ihl = 4'($urandom_range(0, 4));
					3: p.tot_len = 16'($urandom_range(p.len + 1, 65535));
					4: p.len = 17'($urandom_range(1, p.len - 1));
					default: p.dest = $urandom;
				endcase
			end
			build_packet(p, 1'b1);
		end
		random_words += pkt_bytes.size();
		send_packet(1'b0, result_t'('0));
	endtask

	// result checker and receiver stalls
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata[33:0]);
			if (pending_verdicts.size() == 0) begin
				mismatch_count++;
				if (mismatch_count < 30) begin
					$display("%0t: unexpected word verdict=%0d proto=%0d payload=%0d hdr=%0d",
						$time, got.verdict, got.protocol, got.payload_length,
						got.header_length);
				end
			end else begin
				want = pending_verdicts.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count < 30) begin
						$display("%0t: exp verdict=%0d proto=%0d payload=%0d hdr=%0d, got verdict=%0d proto=%0d payload=%0d hdr=%0d",
							$time, want.verdict, want.protocol, want.payload_length,
							want.header_length, got.verdict, got.protocol,
							got.payload_length, got.header_length);
					end
				end
			end
		end
		if ($urandom_range(0, 299) == 0) steady_recv = !steady_recv;
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			if (!steady_recv && $urandom_range(0, 2) == 0) stall_left = pick_gap();
		end
	end

	initial begin
		logic [31:0] phase_addr [5];
		int unsigned n;
		phase_addr[0] = 32'h0;
		phase_addr[1] = BROADCAST_ADDR;
		phase_addr[2] = $urandom;
		phase_addr[3] = LOCAL_A;
		phase_addr[4] = $urandom;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register still at its reset value
		repeat (4) send_random_packet();
		wait_all_verdicts();
		write_local(LOCAL_A);

		for (int i = 0; i < $size(DIRECTED_PLAN); i++) begin
			build_packet(DIRECTED_PLAN[i], 1'b0);
			steady_send = DIRECTED_PLAN[i].len > 1000;
			send_packet(DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].exp);
		end
		steady_send = 1'b0;
		random_words = 0;

		n = 0;
		while (random_words < RANDOM_WORDS || n < RANDOM_PACKETS) begin
			if (n % 10 == 0) begin
				wait_all_verdicts();
				write_local(phase_addr[(n / 10) % 5]);
			end
			steady_send = ($urandom_range(0, 3) == 0);
			send_random_packet();
			n++;
		end

		wait_all_verdicts();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ipv4rx_pkg.sv
rtl/core/ipv4rx_hdr_track.sv
rtl/core/ipv4rx_verdict.sv
rtl/core/ipv4_receive_header_check.sv
sim/tb_ipv4_receive_header_check.sv
